// ===== hdl/rdmw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdmw_pkg
// Shared types, codes and helpers of the random depth-first maze walker.
// ----------------------------------------------------------------------------
package rdmw_pkg;

  localparam int GRID_WIDTH  = 8;
  localparam int GRID_HEIGHT = 8;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  localparam logic [1:0] ST_CARVED   = 2'd0;
  localparam logic [1:0] ST_FINISHED = 2'd1;
  localparam logic [1:0] ST_STARTED  = 2'd2;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  localparam logic REG_START_X = 1'b0;
  localparam logic REG_START_Y = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [15:0] random_word;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] from_x;
    logic [2:0] from_y;
    logic [1:0] move_dir;
  } out_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_SEED,
    S_TOP,
    S_CELL,
    S_NBR,
    S_FOLD,
    S_PICK
  } state_t;

  typedef struct packed {
    logic latch;
    logic clr_step;
    logic seed;
    logic top_rd;
    logic cell_load;
    logic nb_step;
    logic nb_fold;
    logic pick;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic empty;
    logic dir_last;
    logic no_open;
  } ctrl_sts_t;

  // 4 = 1 mod 3, so base-4 digit sums keep the residue
  function automatic logic [1:0] mod3_16(input logic [15:0] v);
    logic [4:0] s;
    logic [2:0] t;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 5'(v[2*i +: 2]);
    end
    t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    if (t >= 3'd6) begin
      t = t - 3'd6;
    end else if (t >= 3'd3) begin
      t = t - 3'd3;
    end
    return t[1:0];
  endfunction

endpackage

// ===== hdl/rdmw_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdmw_ctrl
// Sequencer of the maze walker: clear sweep, seed, stack pop and neighbour scan.
// ----------------------------------------------------------------------------
module rdmw_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                item_cmd,
  input  rdmw_pkg::ctrl_sts_t sts,
  output rdmw_pkg::ctrl_cmd_t cmd,
  output logic                busy
);

  rdmw_pkg::state_t state_r;
  rdmw_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rdmw_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = (state_r != rdmw_pkg::S_IDLE);
    case (state_r)
      rdmw_pkg::S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = (item_cmd == rdmw_pkg::CMD_START) ? rdmw_pkg::S_CLEAR : rdmw_pkg::S_TOP;
        end
      end
      rdmw_pkg::S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) begin
          state_nxt = rdmw_pkg::S_SEED;
        end
      end
      rdmw_pkg::S_SEED: begin
        cmd.seed  = 1'b1;
        state_nxt = rdmw_pkg::S_IDLE;
      end
      rdmw_pkg::S_TOP: begin
        if (sts.empty) begin
          cmd.finish = 1'b1;
          state_nxt  = rdmw_pkg::S_IDLE;
        end else begin
          cmd.top_rd = 1'b1;
          state_nxt  = rdmw_pkg::S_CELL;
        end
      end
      rdmw_pkg::S_CELL: begin
        cmd.cell_load = 1'b1;
        state_nxt     = rdmw_pkg::S_NBR;
      end
      rdmw_pkg::S_NBR: begin
        cmd.nb_step = 1'b1;
        if (sts.dir_last) begin
          state_nxt = rdmw_pkg::S_FOLD;
        end
      end
      rdmw_pkg::S_FOLD: begin
        cmd.nb_fold = 1'b1;
        state_nxt   = rdmw_pkg::S_PICK;
      end
      rdmw_pkg::S_PICK: begin
        cmd.pick  = 1'b1;
        state_nxt = sts.no_open ? rdmw_pkg::S_TOP : rdmw_pkg::S_IDLE;
      end
      default: begin
        state_nxt = rdmw_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/rdmw_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdmw_datapath
// Visited map, cell stack, neighbour scan and result register of the walker.
// ----------------------------------------------------------------------------
module rdmw_datapath #(
  parameter int GridWidth  = rdmw_pkg::GRID_WIDTH,
  parameter int GridHeight = rdmw_pkg::GRID_HEIGHT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rdmw_pkg::ctrl_cmd_t cmd,
  output rdmw_pkg::ctrl_sts_t sts,
  input  rdmw_pkg::in_word_t  in_word,
  input  logic [2:0]          cfg_start_x,
  input  logic [2:0]          cfg_start_y,
  output logic                out_valid,
  output rdmw_pkg::out_word_t out_word
);

  localparam int NCells = GridWidth * GridHeight;
  localparam int CellW  = $clog2(NCells);
  localparam int XW     = $clog2(GridWidth);
  localparam int YW     = $clog2(GridHeight);
  localparam int DepthW = $clog2(NCells + 1);

  logic              vis_mem [NCells];
  logic [YW+XW-1:0]  stk_mem [NCells];

  logic              vis_rd_r;
  logic [YW+XW-1:0]  stk_rd_r;
  logic [15:0]       rnd_r;
  logic [1:0]        rnd3_r;
  logic [CellW-1:0]  clr_r;
  logic [DepthW-1:0] depth_r;
  logic [XW-1:0]     cur_x_r;
  logic [YW-1:0]     cur_y_r;
  logic [1:0]        dir_r;
  logic [3:0]        mask_r;
  logic [1:0]        pend_dir_r;
  logic              pend_inb_r;
  logic              out_valid_r;
  rdmw_pkg::out_word_t out_word_r;

  logic              rd_inb;
  logic [XW-1:0]     rd_nx;
  logic [YW-1:0]     rd_ny;
  logic [CellW-1:0]  rd_addr;
  logic [2:0]        n_open;
  logic [1:0]        sel;
  logic [2:0]        cnt;
  logic [1:0]        pick_dir;
  logic              pk_inb;
  logic [XW-1:0]     pk_nx;
  logic [YW-1:0]     pk_ny;
  logic [CellW-1:0]  pk_idx;
  logic              open_any;
  logic              push_ok;
  logic [DepthW-1:0] depth_m1;
  logic [CellW-1:0]  top_idx;
  logic [CellW-1:0]  push_idx;
  logic [XW-1:0]     sx;
  logic [YW-1:0]     sy;
  logic [CellW-1:0]  seed_idx;
  logic              vis_we;
  logic [CellW-1:0]  vis_wa;
  logic              vis_wd;
  logic              stk_we;
  logic [CellW-1:0]  stk_wa;
  logic [YW+XW-1:0]  stk_wd;

  // returns {in_grid, y, x} of the neighbour in direction d
  function automatic logic [YW+XW:0] nb_of(input logic [1:0] d, input logic [XW-1:0] x,
                                           input logic [YW-1:0] y);
    logic [XW-1:0] nx;
    logic [YW-1:0] ny;
    logic          ok;
    nx = x;
    ny = y;
    ok = 1'b0;
    case (d)
      rdmw_pkg::DIR_UP: begin
        ok = (y != '0);
        ny = y - YW'(1);
      end
      rdmw_pkg::DIR_LEFT: begin
        ok = (x != '0);
        nx = x - XW'(1);
      end
      rdmw_pkg::DIR_DOWN: begin
        ok = (32'(y) != GridHeight - 1);
        ny = y + YW'(1);
      end
      rdmw_pkg::DIR_RIGHT: begin
        ok = (32'(x) != GridWidth - 1);
        nx = x + XW'(1);
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    return {ok, ny, nx};
  endfunction

  function automatic logic [CellW-1:0] cell_idx(input logic [YW-1:0] y, input logic [XW-1:0] x);
    return CellW'(CellW'(y) * CellW'(GridWidth) + CellW'(x));
  endfunction

  always_comb begin
    {rd_inb, rd_ny, rd_nx} = nb_of(dir_r, cur_x_r, cur_y_r);
    rd_addr = rd_inb ? cell_idx(rd_ny, rd_nx) : '0;

    n_open = 3'(mask_r[0]) + 3'(mask_r[1]) + 3'(mask_r[2]) + 3'(mask_r[3]);
    case (n_open)
      3'd2:    sel = {1'b0, rnd_r[0]};
      3'd3:    sel = rnd3_r;
      3'd4:    sel = rnd_r[1:0];
      default: sel = 2'd0;
    endcase

    pick_dir = rdmw_pkg::DIR_UP;
    cnt      = '0;
    for (int k = 0; k < 4; k++) begin
      if (mask_r[k]) begin
        if (cnt == {1'b0, sel}) begin
          pick_dir = 2'(k);
        end
        cnt = cnt + 3'd1;
      end
    end
    {pk_inb, pk_ny, pk_nx} = nb_of(pick_dir, cur_x_r, cur_y_r);
    pk_idx   = cell_idx(pk_ny, pk_nx);
    open_any = (mask_r != '0);
    push_ok  = (32'(depth_r) < NCells);

    depth_m1 = depth_r - DepthW'(1);
    top_idx  = depth_m1[CellW-1:0];
    push_idx = depth_r[CellW-1:0];

    sx = (32'(cfg_start_x) >= GridWidth)  ? XW'(GridWidth - 1)  : XW'(cfg_start_x);
    sy = (32'(cfg_start_y) >= GridHeight) ? YW'(GridHeight - 1) : YW'(cfg_start_y);
    seed_idx = cell_idx(sy, sx);

    vis_we = cmd.clr_step | cmd.seed | (cmd.pick & open_any);
    vis_wa = cmd.clr_step ? clr_r : (cmd.seed ? seed_idx : pk_idx);
    vis_wd = !cmd.clr_step;

    stk_we = cmd.seed | (cmd.pick & open_any & push_ok);
    stk_wa = cmd.seed ? '0 : push_idx;
    stk_wd = cmd.seed ? {sy, sx} : {pk_ny, pk_nx};

    sts.clr_done = (clr_r == CellW'(NCells - 1));
    sts.empty    = (depth_r == '0);
    sts.dir_last = (dir_r == 2'd3);
    sts.no_open  = !open_any;
  end

  always_ff @(posedge clk) begin
    if (vis_we) begin
      vis_mem[vis_wa] <= vis_wd;
    end
    vis_rd_r <= vis_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    if (cmd.top_rd) begin
      stk_rd_r <= stk_mem[top_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.seed | cmd.finish | (cmd.pick & open_any);
      if (cmd.seed) begin
        depth_r <= DepthW'(1);
      end else if (cmd.pick && open_any && push_ok) begin
        depth_r <= depth_r + DepthW'(1);
      end else if (cmd.pick && !open_any) begin
        depth_r <= depth_m1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      rnd_r  <= in_word.random_word;
      rnd3_r <= rdmw_pkg::mod3_16(in_word.random_word);
      clr_r  <= '0;
    end else if (cmd.clr_step) begin
      clr_r <= clr_r + CellW'(1);
    end

    if (cmd.cell_load) begin
      cur_x_r <= stk_rd_r[XW-1:0];
      cur_y_r <= stk_rd_r[XW +: YW];
      dir_r   <= '0;
      mask_r  <= '0;
    end else begin
      if (cmd.nb_step) begin
        dir_r      <= dir_r + 2'd1;
        pend_dir_r <= dir_r;
        pend_inb_r <= rd_inb;
      end
      if ((cmd.nb_step && dir_r != 2'd0) || cmd.nb_fold) begin
        mask_r[pend_dir_r] <= pend_inb_r & ~vis_rd_r;
      end
    end

    if (cmd.seed) begin
      out_word_r <= '{status: rdmw_pkg::ST_STARTED, from_x: 3'(sx), from_y: 3'(sy),
                      move_dir: rdmw_pkg::DIR_UP};
    end else if (cmd.finish) begin
      out_word_r <= '{status: rdmw_pkg::ST_FINISHED, from_x: 3'd0, from_y: 3'd0,
                      move_dir: rdmw_pkg::DIR_UP};
    end else if (cmd.pick && open_any) begin
      out_word_r <= '{status: rdmw_pkg::ST_CARVED, from_x: 3'(cur_x_r), from_y: 3'(cur_y_r),
                      move_dir: pick_dir};
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ===== hdl/random_dfs_maze_walker_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// random_dfs_maze_walker_unit
// Recursive backtracker maze walk over a grid, at most one carved edge per step word.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+----------------------------
//  input    | start, busy, in_word                    | taken when start & !busy
//  result   | out_valid, out_word                     | one-cycle strobe, no stall
//  config   | psel, penable, pwrite, paddr, pwdata,   | APB, pready tied high
//           | prdata, pready                          |
//
//  Step word: the neighbour scan (stack read, cell load, four visited-map reads,
//  fold, pick) runs for the top cell, and again for each cell popped while
//  backtracking. A step that finds the stack empty ends with a finished word.
//  Start word: one visited-map clear sweep over all GridWidth*GridHeight cells,
//  then the seed. The visited map has a single read port. The result word
//  appears in the same cycle that busy falls. Reset leaves the stack empty; the
//  visited map's contents are only used after a start has cleared it.
// ----------------------------------------------------------------------------
module random_dfs_maze_walker_unit #(
  parameter int GridWidth  = rdmw_pkg::GRID_WIDTH,
  parameter int GridHeight = rdmw_pkg::GRID_HEIGHT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  rdmw_pkg::in_word_t  in_word,
  output logic                out_valid,
  output rdmw_pkg::out_word_t out_word,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [2:0] start_x_r;
  logic [2:0] start_y_r;
  logic       cfg_wr;

  rdmw_pkg::ctrl_cmd_t cmd;
  rdmw_pkg::ctrl_sts_t sts;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r <= '0;
      start_y_r <= '0;
    end else if (cfg_wr) begin
      case (paddr[2])
        rdmw_pkg::REG_START_X: start_x_r <= pwdata[2:0];
        rdmw_pkg::REG_START_Y: start_y_r <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      rdmw_pkg::REG_START_X: prdata = {29'd0, start_x_r};
      rdmw_pkg::REG_START_Y: prdata = {29'd0, start_y_r};
      default:               prdata = '0;
    endcase
  end

  rdmw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .item_cmd (in_word.cmd),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy)
  );

  rdmw_datapath #(
    .GridWidth  (GridWidth),
    .GridHeight (GridHeight)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_word     (in_word),
    .cfg_start_x (start_x_r),
    .cfg_start_y (start_y_r),
    .out_valid   (out_valid),
    .out_word    (out_word)
  );

endmodule

// ===== sim/random_dfs_maze_walker_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// random_dfs_maze_walker_unit_tb
// Self-checking bench for the recursive backtracker maze walker. A behavioural
// copy of the walk (visited map, cell stack, start registers) predicts each
// result word; results are matched in order against the predictions. Directed
// corner walks come first, then randomised walks with random start cells,
// partial walks, mid-walk restarts and random sender gaps.
// ----------------------------------------------------------------------------
module random_dfs_maze_walker_unit_tb;

  localparam int GridW    = rdmw_pkg::GRID_WIDTH;
  localparam int GridH    = rdmw_pkg::GRID_HEIGHT;
  localparam int NumCells = GridW * GridH;
  localparam int NumWords = 1950;

  class dfs_walk_predictor;
    bit                  visited [NumCells];
    int                  cells [NumCells];
    int                  depth;
    logic [2:0]          col0;
    logic [2:0]          row0;
    rdmw_pkg::out_word_t pending[$];
    int                  errors;

    function new();
      foreach (visited[i]) visited[i] = 1'b0;
      foreach (cells[i]) cells[i] = 0;
      depth  = 0;
      col0   = '0;
      row0   = '0;
      errors = 0;
    endfunction

    function void set_reg(input logic idx, input logic [31:0] val);
      if (idx == rdmw_pkg::REG_START_X) begin
        col0 = val[2:0];
      end else begin
        row0 = val[2:0];
      end
    endfunction

    function void take_word(input rdmw_pkg::in_word_t w);
      rdmw_pkg::out_word_t r;
      logic [1:0]          free_dir [4];
      logic [1:0]          d;
      int                  c, cx, cy, n, nc;
      bit                  carved;
      r = '0;
      if (w.cmd == rdmw_pkg::CMD_START) begin
        cx = (col0 < GridW) ? int'(col0) : GridW - 1;
        cy = (row0 < GridH) ? int'(row0) : GridH - 1;
        c  = cy * GridW + cx;
        foreach (visited[i]) visited[i] = 1'b0;
        visited[c] = 1'b1;
        cells[0]   = c;
        depth      = 1;
        r.status   = rdmw_pkg::ST_STARTED;
        r.from_x   = 3'(cx);
        r.from_y   = 3'(cy);
        r.move_dir = rdmw_pkg::DIR_UP;
      end else begin
        r.status = rdmw_pkg::ST_FINISHED;
        carved   = 1'b0;
        while (depth > 0 && !carved) begin
          c  = cells[depth-1];
          cx = c % GridW;
          cy = c / GridW;
          n  = 0;
          if (cy > 0 && !visited[c-GridW]) begin
            free_dir[n] = rdmw_pkg::DIR_UP;
            n++;
          end
          if (cx > 0 && !visited[c-1]) begin
            free_dir[n] = rdmw_pkg::DIR_LEFT;
            n++;
          end
          if (cy + 1 < GridH && !visited[c+GridW]) begin
            free_dir[n] = rdmw_pkg::DIR_DOWN;
            n++;
          end
          if (cx + 1 < GridW && !visited[c+1]) begin
            free_dir[n] = rdmw_pkg::DIR_RIGHT;
            n++;
          end
          if (n == 0) begin
            depth--;
          end else begin
            d = free_dir[int'(w.random_word) % n];
            case (d)
              rdmw_pkg::DIR_UP:   nc = c - GridW;
              rdmw_pkg::DIR_LEFT: nc = c - 1;
              rdmw_pkg::DIR_DOWN: nc = c + GridW;
              default:            nc = c + 1;
            endcase
            visited[nc] = 1'b1;
            if (depth < NumCells) begin
              cells[depth] = nc;
              depth++;
            end
            r.status   = rdmw_pkg::ST_CARVED;
            r.from_x   = 3'(cx);
            r.from_y   = 3'(cy);
            r.move_dir = d;
            carved     = 1'b1;
          end
        end
      end
      pending.push_back(r);
    endfunction

    task report(input string msg);
      errors++;
      $display("mismatch at %0t: %s", $time, msg);
    endtask

    task match_result(input rdmw_pkg::out_word_t got);
      rdmw_pkg::out_word_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result word %h", got));
      end else begin
        want = pending.pop_front();
        if (got.status !== want.status)
          report($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.from_x !== want.from_x)
          report($sformatf("from_x %0d, want %0d", got.from_x, want.from_x));
        if (got.from_y !== want.from_y)
          report($sformatf("from_y %0d, want %0d", got.from_y, want.from_y));
        if (got.move_dir !== want.move_dir)
          report($sformatf("move_dir %0d, want %0d", got.move_dir, want.move_dir));
      end
    endtask
  endclass

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  rdmw_pkg::in_word_t  in_word;
  logic                out_valid;
  rdmw_pkg::out_word_t out_word;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  dfs_walk_predictor board;
  int                sent_words;

  random_dfs_maze_walker_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) board.match_result(out_word);
  end

  task automatic send_word(input logic cmd, input logic [15:0] rnd);
    @(negedge clk);
    start               = 1'b1;
    in_word.cmd         = cmd;
    in_word.random_word = rnd;
    do @(posedge clk); while (busy);
    board.take_word(in_word);
    sent_words++;
  endtask

  task automatic sender_gap(input bit off);
    if (!off && $urandom_range(0, 2) == 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat ($urandom_range(0, 10)) @(negedge clk);
    end
  endtask

  // block is idle once the last result word is in
  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [2:0] val);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = {29'($urandom), val};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    board.set_reg(idx, pwdata);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    bit   quiet;
    bit   steady;
    int   steps;
    logic cmd;
    board   = new();
    sent_words = 0;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_word = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // step with an empty stack, then corner start cells
    send_word(rdmw_pkg::CMD_STEP, 16'h0000);
    send_word(rdmw_pkg::CMD_STEP, 16'hFFFF);
    settle();
    write_reg(rdmw_pkg::REG_START_X, 3'd7);
    write_reg(rdmw_pkg::REG_START_Y, 3'd7);
    send_word(rdmw_pkg::CMD_START, 16'hFFFF);
    send_word(rdmw_pkg::CMD_STEP, 16'h0000);
    send_word(rdmw_pkg::CMD_STEP, 16'hFFFF);
    send_word(rdmw_pkg::CMD_STEP, 16'h8000);
    send_word(rdmw_pkg::CMD_STEP, 16'h0001);
    settle();
    write_reg(rdmw_pkg::REG_START_X, 3'd0);
    write_reg(rdmw_pkg::REG_START_Y, 3'd0);
    send_word(rdmw_pkg::CMD_START, 16'h0000);
    send_word(rdmw_pkg::CMD_STEP, 16'h0002);
    send_word(rdmw_pkg::CMD_STEP, 16'h0003);
    send_word(rdmw_pkg::CMD_STEP, 16'h7FFF);
    settle();
    write_reg(rdmw_pkg::REG_START_X, 3'd7);
    send_word(rdmw_pkg::CMD_START, 16'h5555);
    send_word(rdmw_pkg::CMD_STEP, 16'hAAAA);
    send_word(rdmw_pkg::CMD_STEP, 16'hFFFF);
    send_word(rdmw_pkg::CMD_START, 16'h0000);
    send_word(rdmw_pkg::CMD_STEP, 16'h0001);
    settle();
    write_reg(rdmw_pkg::REG_START_X, 3'd0);
    write_reg(rdmw_pkg::REG_START_Y, 3'd7);
    send_word(rdmw_pkg::CMD_START, 16'h1234);
    send_word(rdmw_pkg::CMD_STEP, 16'hFFFE);
    send_word(rdmw_pkg::CMD_STEP, 16'h0000);

    while (sent_words < NumWords) begin
      quiet  = sent_words >= NumWords - 250;
      steady = $urandom_range(0, 4) == 0;
      settle();
      if ($urandom_range(0, 3) != 0)
        write_reg(rdmw_pkg::REG_START_X, 3'($urandom_range(0, 7)));
      if ($urandom_range(0, 3) != 0)
        write_reg(rdmw_pkg::REG_START_Y, 3'($urandom_range(0, 7)));
      // full walk plus a few finished steps, or a partial walk
      steps = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 63)
                                          : NumCells + $urandom_range(0, 3);
      sender_gap(quiet || steady);
      send_word(rdmw_pkg::CMD_START, pick_word());
      for (int k = 0; k < steps; k++) begin
        sender_gap(quiet || steady);
        cmd = ($urandom_range(0, 49) == 0) ? rdmw_pkg::CMD_START : rdmw_pkg::CMD_STEP;
        send_word(cmd, pick_word());
      end
    end

    @(negedge clk);
    start = 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (board.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
